// ----- src/dsvs_pkg.sv -----
package dsvs_pkg;

    // field byte codes
    localparam logic [7:0] CHAR_NUL   = 8'd0;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_QUOTE = 8'd34;
    localparam logic [7:0] CHAR_DEL   = 8'd127;

    // escape table geometry
    localparam int ESCAPE_SLOTS = 8;
    localparam int USED_W       = 4;

    // result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // configuration register indexes
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELIMITER     = 3'd0,
        REG_ESCAPE_BYTE   = 3'd1,
        REG_KEEP_INVALID  = 3'd2,
        REG_ENTRIES_USED  = 3'd3,
        REG_ESCAPE_KEYS   = 3'd4,
        REG_ESCAPE_VALUES = 3'd5
    } reg_index_t;

    // configuration reset values
    localparam logic [7:0]        RST_DELIMITER   = 8'd44;
    localparam logic [7:0]        RST_ESCAPE_BYTE = 8'd92;
    localparam logic              RST_KEEP        = 1'b1;
    localparam logic [USED_W-1:0] RST_USED        = '0;

    typedef struct packed {
        logic [7:0]        delimiter;
        logic [7:0]        escape_byte;
        logic              keep_invalid_escape;
        logic [USED_W-1:0] escape_entries_used;
        logic [63:0]       escape_keys;
        logic [63:0]       escape_values;
    } cfg_t;

    typedef struct packed {
        logic       has_char;
        logic [7:0] out_char;
        logic       field_end;
        logic       line_end;
        logic       last;
    } result_t;

    // up to two results written into the queue in one cycle
    typedef struct packed {
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage

// ----- src/dsvs_cfg_regs.sv -----
module dsvs_cfg_regs
    import dsvs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [63:0]          wr_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_index_t'(wr_index))
                REG_DELIMITER:     cfg_next.delimiter           = wr_data[7:0];
                REG_ESCAPE_BYTE:   cfg_next.escape_byte         = wr_data[7:0];
                REG_KEEP_INVALID:  cfg_next.keep_invalid_escape = wr_data[0];
                REG_ENTRIES_USED:  cfg_next.escape_entries_used = wr_data[USED_W-1:0];
                REG_ESCAPE_KEYS:   cfg_next.escape_keys         = wr_data;
                REG_ESCAPE_VALUES: cfg_next.escape_values       = wr_data;
                default:           cfg_next                     = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delimiter           <= RST_DELIMITER;
            cfg_reg.escape_byte         <= RST_ESCAPE_BYTE;
            cfg_reg.keep_invalid_escape <= RST_KEEP;
            cfg_reg.escape_entries_used <= RST_USED;
            cfg_reg.escape_keys         <= '0;
            cfg_reg.escape_values       <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/dsvs_core.sv -----
module dsvs_core
    import dsvs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       step,
    input  logic [7:0] ch,
    output push_t      push
);

    logic in_escape_reg, in_escape_next;
    logic in_quotes_reg, in_quotes_next;
    logic field_started_reg, field_started_next;

    logic              ignored;
    logic              is_delim;
    logic              close_has;
    logic              close_fe;
    logic              hit;
    logic [7:0]        hit_val;
    logic [USED_W-1:0] used_clamped;

    // escape table, lowest matching slot wins
    always_comb
    begin
        used_clamped = (cfg.escape_entries_used > USED_W'(ESCAPE_SLOTS))
                     ? USED_W'(ESCAPE_SLOTS) : cfg.escape_entries_used;
        hit     = 1'b0;
        hit_val = '0;
        for (int i = ESCAPE_SLOTS - 1; i >= 0; i--)
        begin
            if ((USED_W'(i) < used_clamped) && (cfg.escape_keys[8*i +: 8] == ch))
            begin
                hit     = 1'b1;
                hit_val = cfg.escape_values[8*i +: 8];
            end
        end
    end

    always_comb
    begin
        ignored   = (ch != CHAR_TAB) && ((ch < CHAR_SPACE) || (ch >= CHAR_DEL));
        is_delim  = !in_quotes_reg && (ch == cfg.delimiter);
        close_has = in_escape_reg && cfg.keep_invalid_escape;
        close_fe  = field_started_reg || close_has;

        in_escape_next     = in_escape_reg;
        in_quotes_next     = in_quotes_reg;
        field_started_next = field_started_reg;
        push               = '0;

        if (step)
        begin
            priority if (ch == CHAR_NUL)
            begin
                push.n            = 2'd1;
                push.r0.has_char  = close_has;
                push.r0.out_char  = close_has ? cfg.escape_byte : 8'd0;
                push.r0.field_end = close_fe;
                push.r0.line_end  = 1'b1;
                push.r0.last      = 1'b1;
                in_escape_next     = 1'b0;
                in_quotes_next     = 1'b0;
                field_started_next = 1'b0;
            end
            else if (ignored)
            begin
                push.n = 2'd0;
            end
            else if (is_delim)
            begin
                // pending escape survives the delimiter unless it is emitted
                if (close_has)
                    in_escape_next = 1'b0;
                field_started_next = 1'b0;
                if (close_fe)
                begin
                    push.n            = 2'd1;
                    push.r0.has_char  = close_has;
                    push.r0.out_char  = close_has ? cfg.escape_byte : 8'd0;
                    push.r0.field_end = 1'b1;
                    push.r0.last      = 1'b1;
                end
            end
            else if (in_escape_reg)
            begin
                in_escape_next = 1'b0;
                if (hit)
                begin
                    push.n             = 2'd1;
                    push.r0.has_char   = 1'b1;
                    push.r0.out_char   = hit_val;
                    push.r0.last       = 1'b1;
                    field_started_next = 1'b1;
                end
                else if (cfg.keep_invalid_escape)
                begin
                    push.n             = 2'd2;
                    push.r0.has_char   = 1'b1;
                    push.r0.out_char   = cfg.escape_byte;
                    push.r1.has_char   = 1'b1;
                    push.r1.out_char   = ch;
                    push.r1.last       = 1'b1;
                    field_started_next = 1'b1;
                end
            end
            else if ((cfg.escape_entries_used != '0) && (ch == cfg.escape_byte))
            begin
                in_escape_next = 1'b1;
            end
            else if (ch == CHAR_QUOTE)
            begin
                in_quotes_next = !in_quotes_reg;
            end
            else
            begin
                push.n             = 2'd1;
                push.r0.has_char   = 1'b1;
                push.r0.out_char   = ch;
                push.r0.last       = 1'b1;
                field_started_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_escape_reg     <= 1'b0;
            in_quotes_reg     <= 1'b0;
            field_started_reg <= 1'b0;
        end
        else
        begin
            in_escape_reg     <= in_escape_next;
            in_quotes_reg     <= in_quotes_next;
            field_started_reg <= field_started_next;
        end
    end

`ifndef SYNTHESIS
    a_line_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (ch == CHAR_NUL)) |=> (!in_escape_reg && !in_quotes_reg && !field_started_reg))
        else $error("line end left parser state set");

    a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n == 2'd2) |-> (push.r1.last && !push.r0.last && push.r0.has_char))
        else $error("two-result item marked wrong");
`endif

endmodule

// ----- src/dsvs_result_fifo.sv -----
module dsvs_result_fifo
    import dsvs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    room,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t head
);

    result_t                mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]  count_reg, count_next;
    logic [FIFO_PTR_W-1:0]  wr_ptr_plus1;
    logic                   pop;

    assign wr_ptr_plus1 = wr_ptr_reg + FIFO_PTR_W'(1);
    assign pop          = (count_reg != '0) && !out_stall;
    // room for the worst case of two results
    assign room         = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign out_valid    = (count_reg != '0);
    assign head         = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push.n);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + FIFO_CNT_W'(push.n) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
            mem_reg[wr_ptr_reg] <= push.r0;
        if (push.n == 2'd2)
            mem_reg[wr_ptr_plus1] <= push.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n != 2'd0) |-> (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2)))
        else $error("results pushed without room");

    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");
`endif

endmodule

// ----- src/dsv_field_splitter.sv -----
// channel   | handshake              | payload
// ----------+------------------------+-------------------------------------------------
// input     | in_valid / in_stall    | ch
// result    | out_valid / out_stall  | has_char, out_char, field_end, line_end, last
// config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one item per cycle sustained while the result queue has room; an item is
// registered at accept, decoded once the queue has room and written into a 4-entry
// result queue, so its first result is on the port once it is in the queue
// an escape with no table match can give two results when invalid escapes are kept;
// the queue absorbs them, input stalls only when the queue has fewer than two free entries
// rst_n is asynchronous: parser flags clear, config returns to its reset values
// cfg_ready is always high; user writes config only while block is idle (unenforced)
module dsv_field_splitter
    import dsvs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           ch,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 has_char,
    output logic [7:0]           out_char,
    output logic                 field_end,
    output logic                 line_end,
    output logic                 last,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);

    cfg_t       cfg;
    push_t      push;
    result_t    head;
    logic       room;
    logic       step;
    logic       in_accept;
    logic       in_valid_reg, in_valid_next;
    logic [7:0] ch_reg;

    assign cfg_ready = 1'b1;

    dsvs_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // input register: decode the held item once the queue can take two results
    assign step          = in_valid_reg && room;
    assign in_stall      = in_valid_reg && !room;
    assign in_accept     = in_valid && !in_stall;
    assign in_valid_next = in_accept || (in_valid_reg && !step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
            ch_reg <= ch;
    end

    dsvs_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .step  (step),
        .ch    (ch_reg),
        .push  (push)
    );

    dsvs_result_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign has_char  = head.has_char;
    assign out_char  = head.out_char;
    assign field_end = head.field_end;
    assign line_end  = head.line_end;
    assign last      = head.last;

`ifndef SYNTHESIS
    a_step_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !room) |=> in_valid_reg)
        else $error("held item lost while queue full");
`endif

endmodule
